// ===== src/wqswe_pkg.sv =====
// Package with shared constants, types and codes for the wait queue engine.
`default_nettype none
package wqswe_pkg;
   localparam int THREADS = 16;
   localparam int TID_W = 4;
   localparam int CNT_W = 5;

   typedef enum logic [1:0] {
      KIND_WAIT = 2'd0,
      KIND_WAKE = 2'd1,
      KIND_TICK = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   localparam logic [1:0] OUT_SUCCESS = 2'd0;
   localparam logic [1:0] OUT_ERROR = 2'd1;
   localparam logic [1:0] OUT_TIMEOUT = 2'd2;

   // Candidate handed from cell to cell while a selection sweep runs.
   typedef struct packed {
      logic found;
      logic [TID_W-1:0] tid;
      logic [63:0] key;
   } cand_type;

   // Command broadcast to every cell.
   typedef struct packed {
      logic wr;
      logic [TID_W-1:0] wr_tid;
      logic [31:0] obj;
      logic [11:0] prio;
      logic [63:0] dl;
      logic clr;
      logic [TID_W-1:0] clr_tid;
      logic is_tick;
      logic target;
      logic [TID_W-1:0] tgt_tid;
      logic [63:0] now;
   } cmd_type;
endpackage
`default_nettype wire

// ===== src/wait_queue_sleep_wake_engine_unit.sv =====
// Top level of the wait queue engine: cell row, control sequencer and result register.
`default_nettype none
// One item is worked on at a time. The candidate moves one cell per cycle; after a release
// the selection sweep waits while the cleared slot settles. The next-deadline scan walks
// the 16 slots one per cycle, pausing while a write or a release settles. A stalled
// receiver holds the engine before it emits the next result.
module wait_queue_sleep_wake_engine_unit import wqswe_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // kind, thread_id, target_only, wait_object, priority_req, timeout_ms,
   // wake_limit, error_code, now_ms
   input  wire logic [159:0] req_tdata,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // woken_valid, woken_thread, outcome, woken_error, wake_count, next_deadline
   output logic [87:0] rsp_tdata,
   output logic rsp_tlast
);
   typedef enum logic [2:0] {
      S_IDLE, S_SEL, S_EMIT, S_SCAN, S_SUM, S_OUT
   } state_type;

   state_type state_ff;
   logic [1:0] kind_ff;
   logic [TID_W-1:0] tid_ff;
   logic target_ff;
   logic [31:0] obj_ff;
   logic [CNT_W-1:0] limit_ff, cnt_ff;
   logic [7:0] err_ff;
   logic [63:0] now_ff;
   cand_type sel_ff;
   logic [TID_W:0] scan_ff;
   logic [63:0] next_ff;
   logic rv_ff;
   logic [87:0] rdata_ff;
   logic rlast_ff;
   logic wr_ff;
   logic [11:0] prio_ff;
   logic [63:0] dlw_ff;
   logic clr_ff;

   cmd_type cmd;
   cand_type chain [THREADS+1];
   logic [63:0] dls [THREADS];
   logic lives [THREADS];
   logic sleeps [THREADS];

   assign chain[0] = '0;
   genvar g;
   for (g = 0; g < THREADS; g++) begin : g_cell
      wqswe_cell u_cell (
         .clock(clock), .reset(reset), .my_id(TID_W'(g)), .cmd(cmd),
         .cand_in(chain[g]), .cand_out(chain[g+1]), .dl_out(dls[g]),
         .live_out(lives[g]), .sleep_out(sleeps[g])
      );
   end

   always_comb begin
      cmd.wr = wr_ff;
      cmd.wr_tid = tid_ff;
      cmd.obj = obj_ff;
      cmd.prio = prio_ff;
      cmd.dl = dlw_ff;
      cmd.clr = clr_ff;
      cmd.clr_tid = sel_ff.tid;
      cmd.is_tick = kind_ff == KIND_TICK;
      cmd.target = target_ff;
      cmd.tgt_tid = tid_ff;
      cmd.now = now_ff;
   end

   logic [64:0] sum;
   assign sum = {1'b0, req_tdata[159:96]} + {33'd0, req_tdata[82:51]};
   logic [TID_W-1:0] sidx;
   assign sidx = scan_ff[TID_W-1:0];

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rdata_ff;
   assign rsp_tlast = rlast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
         wr_ff <= 1'b0;
         clr_ff <= 1'b0;
      end else begin
         wr_ff <= 1'b0;
         clr_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  kind_ff <= req_tdata[1:0];
                  tid_ff <= req_tdata[5:2];
                  target_ff <= req_tdata[6];
                  obj_ff <= req_tdata[38:7];
                  prio_ff <= req_tdata[50:39];
                  limit_ff <= req_tdata[87:83];
                  err_ff <= req_tdata[95:88];
                  now_ff <= req_tdata[159:96];
                  cnt_ff <= '0;
                  if (req_tdata[82:51] == 32'd0) dlw_ff <= 64'd0;
                  else if (sum[64]) dlw_ff <= '1;
                  else dlw_ff <= sum[63:0];
                  if (req_tdata[1:0] == KIND_WAIT) begin
                     wr_ff <= !sleeps[req_tdata[5:2]];
                     state_ff <= S_SCAN;
                  end else if (req_tdata[1:0] == KIND_NONE) begin
                     state_ff <= S_SCAN;
                  end else begin
                     state_ff <= S_SEL;
                  end
                  scan_ff <= '0;
                  next_ff <= 64'd0;
               end
            end
            S_SEL: begin
               if (rv_ff && rsp_tready) rv_ff <= 1'b0;
               if (!clr_ff) begin
                  if (scan_ff == (TID_W+1)'(THREADS)) begin
                     sel_ff <= chain[THREADS];
                     state_ff <= S_EMIT;
                  end else begin
                     scan_ff <= scan_ff + (TID_W+1)'(1);
                  end
               end
            end
            S_EMIT: begin
               scan_ff <= '0;
               if (!sel_ff.found) begin
                  state_ff <= S_SCAN;
               end else if (!rv_ff || rsp_tready) begin
                  rv_ff <= 1'b1;
                  rlast_ff <= 1'b0;
                  clr_ff <= 1'b1;
                  if (kind_ff == KIND_TICK)
                     rdata_ff <= {73'd0, 8'd0, OUT_TIMEOUT, sel_ff.tid, 1'b1};
                  else
                     rdata_ff <= {73'd0, err_ff,
                                  (err_ff != 8'd0) ? OUT_ERROR : OUT_SUCCESS,
                                  sel_ff.tid, 1'b1};
                  if (kind_ff == KIND_WAKE && limit_ff != '0 &&
                      cnt_ff + CNT_W'(1) >= limit_ff) begin
                     cnt_ff <= cnt_ff + CNT_W'(1);
                     state_ff <= S_SCAN;
                  end else begin
                     if (kind_ff == KIND_WAKE && limit_ff != '0)
                        cnt_ff <= cnt_ff + CNT_W'(1);
                     state_ff <= S_SEL;
                  end
               end
               if (rv_ff && rsp_tready && !(sel_ff.found)) rv_ff <= 1'b0;
            end
            S_SCAN: begin
               if (rv_ff && rsp_tready) rv_ff <= 1'b0;
               if (!wr_ff && !clr_ff) begin
                  if (lives[sidx] && (next_ff == 64'd0 || dls[sidx] < next_ff))
                     next_ff <= dls[sidx];
                  if (scan_ff == (TID_W+1)'(THREADS-1)) state_ff <= S_SUM;
                  scan_ff <= scan_ff + (TID_W+1)'(1);
               end
            end
            S_SUM: begin
               if (!rv_ff || rsp_tready) begin
                  rv_ff <= 1'b1;
                  rlast_ff <= 1'b1;
                  rdata_ff <= {4'd0, next_ff,
                               (kind_ff == KIND_WAKE) ? cnt_ff : CNT_W'(0),
                               8'd0, OUT_SUCCESS, TID_W'(0), 1'b0};
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_tready) begin
                  rv_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_tready |=> rv_ff && $stable(rdata_ff))
      else $error("result changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready)
      else $error("accept while busy");
   a_clr_found: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> sel_ff.found)
      else $error("release without candidate");
endmodule
`default_nettype wire

// ===== src/wqswe_cell.sv =====
// One thread slot: holds its sleeper state and improves the passing candidate.
`default_nettype none
module wqswe_cell import wqswe_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [TID_W-1:0] my_id,
   input  cmd_type cmd,
   input  cand_type cand_in,
   output cand_type cand_out,
   output logic [63:0] dl_out,
   output logic live_out,
   output logic sleep_out
);
   logic sleeping_ff, sleeping_in;
   logic [31:0] obj_ff;
   logic [11:0] prio_ff;
   logic [63:0] dl_ff;
   logic [THREADS-1:0] older_ff, older_in;
   cand_type best_ff, best_in;
   logic ok;
   logic [63:0] key;
   logic better;

   always_comb begin
      sleeping_in = sleeping_ff;
      older_in = older_ff;
      if (cmd.wr) begin
         if (cmd.wr_tid == my_id) begin
            sleeping_in = 1'b1;
            older_in = '0;
         end else begin
            older_in[cmd.wr_tid] = 1'b1;
         end
      end
      if (cmd.clr && cmd.clr_tid == my_id) sleeping_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sleeping_ff <= 1'b0;
         older_ff <= '0;
         best_ff <= '0;
      end else begin
         sleeping_ff <= sleeping_in;
         older_ff <= older_in;
         best_ff <= best_in;
      end
      if (cmd.wr && cmd.wr_tid == my_id) begin
         obj_ff <= cmd.obj;
         prio_ff <= cmd.prio;
         dl_ff <= cmd.dl;
      end
   end

   always_comb begin
      if (cmd.is_tick) begin
         ok = sleeping_ff && dl_ff != 64'd0 && dl_ff <= cmd.now;
         key = dl_ff;
      end else begin
         ok = sleeping_ff && obj_ff == cmd.obj && (!cmd.target || cmd.tgt_tid == my_id);
         key = {52'd0, prio_ff};
      end
      // Arrived earlier than the candidate when the candidate's bit is set in ours.
      better = !cand_in.found || key < cand_in.key ||
               (key == cand_in.key && older_ff[cand_in.tid]);
      best_in = cand_in;
      if (ok && better) begin
         best_in.found = 1'b1;
         best_in.tid = my_id;
         best_in.key = key;
      end
   end

   assign cand_out = best_ff;
   assign dl_out = dl_ff;
   assign live_out = sleeping_ff && dl_ff != 64'd0;
   assign sleep_out = sleeping_ff;
endmodule
`default_nettype wire

// ===== sim/wait_queue_sleep_wake_engine_unit_test.sv =====
// Self-checking testbench for the wait queue engine with a built-in predictor and random stimulus.
`default_nettype none
module wait_queue_sleep_wake_engine_unit_test import wqswe_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic woken_valid;
      logic [3:0] woken_thread;
      logic [1:0] outcome;
      logic [7:0] woken_error;
      logic [4:0] wake_count;
      logic [63:0] next_deadline;
      logic last;
   } wake_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [159:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic rsp_tlast;

   bit sleeper_on[THREADS];
   logic [31:0] sleeper_object[THREADS];
   logic [11:0] sleeper_prio[THREADS];
   logic [63:0] sleeper_deadline[THREADS];
   int unsigned sleeper_arrival[THREADS];
   int unsigned arrival_seq = 0;

   wake_report_type pending_reports[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit recv_hold = 1'b0;
   int idle_cycles = 0;
   logic [63:0] clock_ms;
   logic [31:0] object_pool[4];

   wait_queue_sleep_wake_engine_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic void push_report(logic v, logic [3:0] thd, logic [1:0] oc,
                                       logic [7:0] er, logic [4:0] cnt, logic [63:0] nd);
      wake_report_type r;
      r.woken_valid = v;
      r.woken_thread = thd;
      r.outcome = oc;
      r.woken_error = er;
      r.wake_count = cnt;
      r.next_deadline = nd;
      r.last = ~v;
      pending_reports.push_back(r);
   endfunction

   function automatic void predict_wake_queue(logic [159:0] d);
      kind_type kind;
      logic [3:0] tid;
      logic tgt;
      logic [31:0] obj;
      logic [31:0] tmo;
      logic [4:0] lim;
      logic [7:0] er;
      logic [63:0] now;
      logic [63:0] nd;
      logic [63:0] kb;
      logic [63:0] ki;
      logic [4:0] cnt;
      int best;
      bit ok;
      bit done;
      kind = kind_type'(d[1:0]);
      tid = d[5:2];
      tgt = d[6];
      obj = d[38:7];
      tmo = d[82:51];
      lim = d[87:83];
      er = d[95:88];
      now = d[159:96];
      cnt = '0;
      nd = '0;
      if (kind == KIND_WAIT) begin
         if (!sleeper_on[tid]) begin
            sleeper_on[tid] = 1'b1;
            sleeper_object[tid] = obj;
            sleeper_prio[tid] = d[50:39];
            if (tmo == 0) sleeper_deadline[tid] = '0;
            else if (now > ~64'd0 - 64'(tmo)) sleeper_deadline[tid] = ~64'd0;
            else sleeper_deadline[tid] = now + 64'(tmo);
            sleeper_arrival[tid] = arrival_seq++;
         end
      end else if (kind == KIND_WAKE || kind == KIND_TICK) begin
         done = 1'b0;
         while (!done) begin
            best = -1;
            kb = '0;
            for (int i = 0; i < THREADS; i++) begin
               if (kind == KIND_WAKE) begin
                  ok = sleeper_object[i] == obj && (!tgt || i == tid);
                  ki = 64'(sleeper_prio[i]);
               end else begin
                  ok = sleeper_deadline[i] != 0 && sleeper_deadline[i] <= now;
                  ki = sleeper_deadline[i];
               end
               if (sleeper_on[i] && ok) begin
                  if (best < 0 || ki < kb ||
                      (ki == kb && sleeper_arrival[i] < sleeper_arrival[best])) begin
                     best = i;
                     kb = ki;
                  end
               end
            end
            if (best < 0) begin
               done = 1'b1;
            end else begin
               sleeper_on[best] = 1'b0;
               if (kind == KIND_WAKE) begin
                  push_report(1'b1, 4'(best), (er != 0) ? OUT_ERROR : OUT_SUCCESS,
                              er, '0, '0);
                  if (lim != 0) begin
                     cnt++;
                     if (cnt >= lim) done = 1'b1;
                  end
               end else begin
                  push_report(1'b1, 4'(best), OUT_TIMEOUT, '0, '0, '0);
               end
            end
         end
      end
      for (int i = 0; i < THREADS; i++)
         if (sleeper_on[i] && sleeper_deadline[i] != 0 &&
             (nd == 0 || sleeper_deadline[i] < nd))
            nd = sleeper_deadline[i];
      push_report(1'b0, '0, OUT_SUCCESS, '0, cnt, nd);
   endfunction

   task automatic send_item(kind_type kind, logic [3:0] tid, logic tgt, logic [31:0] obj,
                            logic [11:0] prio, logic [31:0] tmo, logic [4:0] lim,
                            logic [7:0] er, logic [63:0] now);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = {now, er, lim, tmo, prio, obj, tgt, tid, kind};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_wake_queue(req_tdata);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   always @(negedge clock)
      rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      wake_report_type got;
      wake_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[0], rsp_tdata[4:1], rsp_tdata[6:5], rsp_tdata[14:7],
                rsp_tdata[19:15], rsp_tdata[83:20], rsp_tlast};
         if (pending_reports.size() == 0) begin
            $error("unexpected result item %h", rsp_tdata);
            errors++;
         end else begin
            want = pending_reports.pop_front();
            if (got.woken_valid !== want.woken_valid) begin
               $error("woken_valid: expected %0d, got %0d", want.woken_valid, got.woken_valid);
               errors++;
            end
            if (got.woken_thread !== want.woken_thread) begin
               $error("woken_thread: expected %0d, got %0d",
                      want.woken_thread, got.woken_thread);
               errors++;
            end
            if (got.outcome !== want.outcome) begin
               $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
               errors++;
            end
            if (got.woken_error !== want.woken_error) begin
               $error("woken_error: expected %0d, got %0d", want.woken_error, got.woken_error);
               errors++;
            end
            if (got.wake_count !== want.wake_count) begin
               $error("wake_count: expected %0d, got %0d", want.wake_count, got.wake_count);
               errors++;
            end
            if (got.next_deadline !== want.next_deadline) begin
               $error("next_deadline: expected %h, got %h",
                      want.next_deadline, got.next_deadline);
               errors++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, got.last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("[wait_queue_sleep_wake_engine_unit] ERROR");
         $finish;
      end
   end

   task automatic test_directed();
      logic [63:0] top_ms;
      top_ms = ~64'd0 - 64'd5;
      send_item(KIND_WAIT, 4'd0, 1'b0, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF, 5'd0, 8'd0, top_ms);
      send_item(KIND_WAIT, 4'd15, 1'b0, 32'hFFFF_FFFF, 12'd0, 32'd0, 5'd0, 8'd0, 64'd0);
      send_item(KIND_WAIT, 4'd15, 1'b0, 32'h0, 12'd5, 32'd9, 5'd0, 8'd0, 64'd0);
      send_item(KIND_WAIT, 4'd3, 1'b0, 32'hFFFF_FFFF, 12'd0, 32'd10, 5'd0, 8'd0, 64'd100);
      send_item(KIND_WAIT, 4'd7, 1'b0, 32'hFFFF_FFFF, 12'd0, 32'd20, 5'd0, 8'd0, 64'd100);
      send_item(KIND_WAIT, 4'd9, 1'b0, 32'h0, 12'd1, 32'd10, 5'd0, 8'd0, 64'd100);
      send_item(KIND_NONE, 4'd15, 1'b1, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF, 5'd31,
                8'hFF, ~64'd0);
      send_item(KIND_WAKE, 4'd7, 1'b1, 32'hFFFF_FFFF, 12'd0, 32'd0, 5'd0, 8'd0, 64'd0);
      send_item(KIND_WAKE, 4'd9, 1'b1, 32'hFFFF_FFFF, 12'd0, 32'd0, 5'd0, 8'd0, 64'd0);
      send_item(KIND_TICK, 4'd0, 1'b0, 32'd0, 12'd0, 32'd0, 5'd0, 8'd0, 64'd110);
      send_item(KIND_WAKE, 4'd0, 1'b0, 32'hFFFF_FFFF, 12'd0, 32'd0, 5'd1, 8'hFF, 64'd0);
      send_item(KIND_WAKE, 4'd0, 1'b0, 32'hFFFF_FFFF, 12'd0, 32'd0, 5'd16, 8'd11, 64'd0);
      for (int i = 0; i < THREADS; i++)
         send_item(KIND_WAIT, 4'(i), 1'b0, 32'h1234_5678, 12'(i % 3), 32'(i + 1), 5'd0,
                   8'd0, 64'd1000);
      send_item(KIND_TICK, 4'd0, 1'b0, 32'd0, 12'd0, 32'd0, 5'd0, 8'd0, ~64'd0);
      drain_results();
   endtask

   task automatic send_random_item();
      int pick;
      logic [31:0] tmo;
      pick = $urandom_range(99);
      if (pick < 45) begin
         case ($urandom_range(9))
            0, 1: tmo = 32'd0;
            2: tmo = $urandom;
            default: tmo = $urandom_range(60, 1);
         endcase
         send_item(KIND_WAIT, 4'($urandom), 1'b0, object_pool[$urandom_range(3)],
                   ($urandom_range(1) != 0) ? 12'($urandom_range(3)) : 12'($urandom),
                   tmo, 5'($urandom), 8'($urandom), clock_ms);
      end else if (pick < 75) begin
         send_item(KIND_WAKE, 4'($urandom), $urandom_range(9) < 3,
                   object_pool[$urandom_range(3)], 12'($urandom), $urandom,
                   ($urandom_range(1) != 0) ? 5'd0 : 5'($urandom_range(16)),
                   ($urandom_range(1) != 0) ? 8'd0 : 8'($urandom), 64'($urandom));
      end else if (pick < 92) begin
         clock_ms = clock_ms + 64'($urandom_range(40));
         send_item(KIND_TICK, 4'($urandom), 1'($urandom), $urandom, 12'($urandom),
                   $urandom, 5'($urandom), 8'($urandom), clock_ms);
      end else begin
         send_item(($urandom_range(1) != 0) ? KIND_NONE : KIND_WAKE, 4'($urandom),
                   1'($urandom), $urandom, 12'($urandom), $urandom, 5'($urandom),
                   8'($urandom), {$urandom, $urandom});
      end
   endtask

   task automatic test_random_phase(int count, int s_pct, int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      clock_ms = {$urandom, $urandom} >> $urandom_range(63);
      for (int i = 0; i < 4; i++) object_pool[i] = $urandom;
      for (int i = 0; i < count; i++) send_random_item();
      drain_results();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fork
         begin
            recv_hold = 1'b1;
            repeat (400) @(posedge clock);
            recv_hold = 1'b0;
         end
         for (int i = 0; i < 30; i++) send_random_item();
      join
      drain_results();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_phase(120, 13, 59);
      test_random_phase(120, 59, 13);
      test_backpressure();
      test_random_phase(120, 0, 0);
      if (errors == 0) begin
         $display("[wait_queue_sleep_wake_engine_unit] OK");
      end else begin
         $display("[wait_queue_sleep_wake_engine_unit] ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
